/* rtl/ypcu_pkg.sv */
package ypcu_pkg;

	localparam int MAX_WIDTH_DEF   = 2048;
	localparam int MAX_HEIGHT_DEF  = 2048;
	localparam int MAX_PAD_DEF     = 62;
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam int PIX_W     = 16;
	localparam int DIM_W     = 12;
	localparam int FACT_W    = 3;
	localparam int PAD_W     = 6;
	localparam int CFG_IDX_W = 3;

	// reciprocal of 3, exact floor for operands below 2**15
	localparam logic [31:0] RECIP3       = 32'd43691;
	localparam int          RECIP3_SHIFT = 17;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ACTIVE_WIDTH,
		CFG_OUTPUT_WIDTH,
		CFG_FRAME_ROWS,
		CFG_HORIZ_FACTOR,
		CFG_VERT_FACTOR,
		CFG_PAD_LUMA,
		CFG_PAD_CB,
		CFG_PAD_CR
	} cfg_idx_t;

	typedef struct packed {
		logic [DIM_W-1:0]  active_width;
		logic [DIM_W-1:0]  output_width;
		logic [DIM_W-1:0]  frame_rows;
		logic [FACT_W-1:0] horiz_chroma_factor;
		logic [FACT_W-1:0] vert_chroma_factor;
		logic [PIX_W-1:0]  pad_luma;
		logic [PIX_W-1:0]  pad_cb;
		logic [PIX_W-1:0]  pad_cr;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		active_width:        12'd720,
		output_width:        12'd720,
		frame_rows:          12'd576,
		horiz_chroma_factor: 3'd2,
		vert_chroma_factor:  3'd2,
		pad_luma:            16'd0,
		pad_cb:              16'd32768,
		pad_cr:              16'd32768
	};

	typedef struct packed {
		logic [PIX_W-1:0] luma_in;
		logic [PIX_W-1:0] cb_in;
		logic [PIX_W-1:0] cr_in;
	} in_item_t;

	typedef struct packed {
		logic [PIX_W-1:0] luma_out;
		logic [PIX_W-1:0] cb_out;
		logic [PIX_W-1:0] cr_out;
		logic             is_padding;
		logic             last_in_run;
		logic             row_end;
		logic             frame_end;
	} out_item_t;

	// one source pixel after classification, waiting for expansion
	typedef struct packed {
		logic [PIX_W-1:0] luma;
		logic [PIX_W-1:0] cb;
		logic [PIX_W-1:0] cr;
		logic [PAD_W-1:0] left_cnt;
		logic [PAD_W-1:0] right_cnt;
		logic             row_last;
		logic             frame_last;
	} cmd_t;

	function automatic logic [FACT_W-1:0] clamp_factor(input logic [FACT_W-1:0] f);
		if (f == '0)
			return FACT_W'(1);
		else if (f > FACT_W'(4))
			return FACT_W'(4);
		else
			return f;
	endfunction

	// x / f for f in 1..4
	function automatic logic [15:0] div_by_factor(input logic [15:0] x,
			input logic [FACT_W-1:0] f);
		logic [RECIP3_SHIFT+15:0] prod;
		prod = (RECIP3_SHIFT+16)'(x) * (RECIP3_SHIFT+16)'(RECIP3);
		case (f)
			FACT_W'(1): return x;
			FACT_W'(2): return x >> 1;
			FACT_W'(3): return prod[RECIP3_SHIFT+15:RECIP3_SHIFT];
			default:    return x >> 2;
		endcase
	endfunction

endpackage

/* rtl/ypcu_ram.sv */
module ypcu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end

endmodule

/* rtl/ypcu_front.sv */
module ypcu_front
	import ypcu_pkg::*;
#(
	parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT  = MAX_HEIGHT_DEF,
	parameter int MAX_PAD     = MAX_PAD_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  cfg_t                               cfg,
	input  logic                               push,
	output logic                               full,
	input  in_item_t                           source,
	input  logic [$clog2(QUEUE_DEPTH+1)-1:0]   q_count,
	output logic                               q_push,
	output cmd_t                               q_data
);

	localparam int CW     = $clog2(MAX_WIDTH);
	localparam int RW     = $clog2(MAX_HEIGHT);
	localparam int AW_W   = $clog2(MAX_WIDTH + 1);
	localparam int FR_W   = $clog2(MAX_HEIGHT + 1);
	localparam int CMPA_W = (AW_W > DIM_W) ? AW_W : DIM_W;
	localparam int CMPF_W = (FR_W > DIM_W) ? FR_W : DIM_W;
	localparam int QCW    = $clog2(QUEUE_DEPTH + 1);

	logic [CW-1:0]    col_q;
	logic [RW-1:0]    row_q;
	logic [1:0]       hp_q;
	logic [1:0]       vp_q;
	logic [PIX_W-1:0] cb_held_q;
	logic [PIX_W-1:0] cr_held_q;

	logic             valid_s1;
	logic             use_ram_s1;
	cmd_t             cmd_s1;

	logic [CMPA_W-1:0] aw_ext, aw_cl, ow_ext, pad_full;
	logic [CMPF_W-1:0] fr_ext, fr_cl;
	logic [AW_W-1:0]   aw, col_p1;
	logic [FR_W-1:0]   fr, row_p1;
	logic [PAD_W-1:0]  pad_sat, left, right;
	logic [FACT_W-1:0] hf, vf, hp_p1, vp_p1;
	logic [15:0]       col_div, groups_raw, groups, ci_wide;
	logic [CW-1:0]     ci;
	logic              row_last, frame_last, capture, accept;
	logic [QCW:0]      fill;
	logic [PIX_W-1:0]  cb_sel, cr_sel;
	logic [2*PIX_W-1:0] ram_rdata;

	always_comb begin
		aw_ext = CMPA_W'(cfg.active_width);
		if (aw_ext == '0)
			aw_cl = CMPA_W'(1);
		else if (aw_ext > CMPA_W'(MAX_WIDTH))
			aw_cl = CMPA_W'(MAX_WIDTH);
		else
			aw_cl = aw_ext;
		aw = AW_W'(aw_cl);

		fr_ext = CMPF_W'(cfg.frame_rows);
		if (fr_ext == '0)
			fr_cl = CMPF_W'(1);
		else if (fr_ext > CMPF_W'(MAX_HEIGHT))
			fr_cl = CMPF_W'(MAX_HEIGHT);
		else
			fr_cl = fr_ext;
		fr = FR_W'(fr_cl);

		ow_ext   = CMPA_W'(cfg.output_width);
		pad_full = (ow_ext > aw_cl) ? ow_ext - aw_cl : '0;
		pad_sat  = (pad_full > CMPA_W'(MAX_PAD)) ? PAD_W'(MAX_PAD) : PAD_W'(pad_full);
		left     = pad_sat >> 1;
		right    = pad_sat - left;

		hf = clamp_factor(cfg.horiz_chroma_factor);
		vf = clamp_factor(cfg.vert_chroma_factor);

		col_p1     = AW_W'(col_q) + AW_W'(1);
		row_p1     = FR_W'(row_q) + FR_W'(1);
		row_last   = col_p1 >= aw;
		frame_last = row_p1 >= fr;

		// chroma group index; the partial group at the row end reuses the last one
		col_div    = div_by_factor(16'(col_q), hf);
		groups_raw = div_by_factor(16'(aw), hf);
		groups     = (groups_raw == '0) ? 16'd1 : groups_raw;
		ci_wide    = (col_div >= groups) ? groups - 16'd1 : col_div;
		ci         = ci_wide[CW-1:0];

		capture = (vp_q == 2'd0) && (hp_q == 2'd0) && (col_div < groups);

		hp_p1 = FACT_W'(hp_q) + FACT_W'(1);
		vp_p1 = FACT_W'(vp_q) + FACT_W'(1);

		// room for the queue contents plus the one in flight
		fill   = (QCW+1)'(q_count) + (QCW+1)'(valid_s1);
		full   = fill >= (QCW+1)'(QUEUE_DEPTH);
		accept = push && !full;

		cb_sel = capture ? source.cb_in : cb_held_q;
		cr_sel = capture ? source.cr_in : cr_held_q;
	end

	ypcu_ram #(
		.WIDTH(2 * PIX_W),
		.DEPTH(MAX_WIDTH)
	) u_line_store (
		.clk   (clk),
		.we    (accept && capture),
		.waddr (ci),
		.wdata ({source.cr_in, source.cb_in}),
		.re    (accept && (vp_q != 2'd0)),
		.raddr (ci),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_q     <= '0;
			hp_q      <= '0;
			vp_q      <= '0;
			cb_held_q <= '0;
			cr_held_q <= '0;
			valid_s1  <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				cb_held_q <= cb_sel;
				cr_held_q <= cr_sel;
				if (row_last) begin
					col_q <= '0;
					hp_q  <= '0;
					if (frame_last) begin
						row_q <= '0;
						vp_q  <= '0;
					end else begin
						row_q <= RW'(row_p1);
						vp_q  <= (vp_p1 >= vf) ? 2'd0 : vp_p1[1:0];
					end
				end else begin
					col_q <= CW'(col_p1);
					hp_q  <= (hp_p1 >= hf) ? 2'd0 : hp_p1[1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			use_ram_s1        <= vp_q != 2'd0;
			cmd_s1.luma       <= source.luma_in;
			cmd_s1.cb         <= cb_sel;
			cmd_s1.cr         <= cr_sel;
			cmd_s1.left_cnt   <= (col_q == '0) ? left : '0;
			cmd_s1.right_cnt  <= row_last ? right : '0;
			cmd_s1.row_last   <= row_last;
			cmd_s1.frame_last <= row_last && frame_last;
		end
	end

	always_comb begin
		q_push = valid_s1;
		q_data = cmd_s1;
		if (use_ram_s1) begin
			q_data.cb = ram_rdata[PIX_W-1:0];
			q_data.cr = ram_rdata[2*PIX_W-1:PIX_W];
		end
	end

endmodule

/* rtl/ypcu_queue.sv */
module ypcu_queue
	import ypcu_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  cmd_t                         wdata,
	input  logic                         pop,
	output cmd_t                         head,
	output logic                         valid,
	output logic [$clog2(DEPTH+1)-1:0]   count
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_pop;

	assign do_pop = pop && (count_q != '0);
	assign valid  = count_q != '0;
	assign head   = mem_q[rd_ptr_q];
	assign count  = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			if (push && !do_pop)
				count_q <= count_q + CW'(1);
			else if (!push && do_pop)
				count_q <= count_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wdata;
	end

endmodule

/* rtl/ypcu_back.sv */
module ypcu_back
	import ypcu_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  cmd_t      head,
	input  logic      head_valid,
	output logic      head_pop,
	output logic      empty,
	input  logic      pop,
	output out_item_t result
);

	logic [PAD_W-1:0] idx_q;
	logic             out_valid_q;
	out_item_t        out_q;

	logic [PAD_W-1:0] last_idx;
	logic             is_pix, is_last, load;
	out_item_t        item;

	always_comb begin
		// left pads, then the pixel, then right pads
		last_idx = head.left_cnt + head.right_cnt;
		is_pix   = idx_q == head.left_cnt;
		is_last  = idx_q == last_idx;
		load     = head_valid && (!out_valid_q || pop);
		head_pop = load && is_last;

		item.luma_out    = is_pix ? head.luma : cfg.pad_luma;
		item.cb_out      = is_pix ? head.cb : cfg.pad_cb;
		item.cr_out      = is_pix ? head.cr : cfg.pad_cr;
		item.is_padding  = !is_pix;
		item.last_in_run = is_last;
		item.row_end     = is_last && head.row_last;
		item.frame_end   = is_last && head.frame_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= is_last ? '0 : idx_q + PAD_W'(1);
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			out_q <= item;
	end

	assign empty  = !out_valid_q;
	assign result = out_q;

endmodule

/* rtl/yuv_pad_chroma_upsample_444_unit.sv */
// channel   direction  handshake            payload
// source    in         push / full          in_item_t (luma, cb, cr)
// result    out        pop / empty          out_item_t (pixel + flags)
// config    in         cfg_write            cfg_index, cfg_data
//
// A source pixel is taken every cycle while no padding is due and pop is held
// high; each pixel occupies the output stage for itself plus its pads (left
// pad on column 0, right pad on the last column); push stalls at row edges or
// when pop is low. Results go through line store read, queue, output register.
// Reset restores the register defaults and clears counters, phases and the
// held chroma; the line store is not cleared.
module yuv_pad_chroma_upsample_444_unit
	import ypcu_pkg::*;
#(
	parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT  = MAX_HEIGHT_DEF,
	parameter int MAX_PAD     = MAX_PAD_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [PIX_W-1:0]     cfg_data,
	input  logic                 push,
	output logic                 full,
	input  in_item_t             source,
	output logic                 empty,
	input  logic                 pop,
	output out_item_t            result
);

	cfg_t cfg_q;
	cmd_t q_wdata, q_head;
	logic q_push, q_pop, q_valid;
	logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_write) begin
			case (cfg_idx_t'(cfg_index))
				CFG_ACTIVE_WIDTH: cfg_q.active_width        <= cfg_data[DIM_W-1:0];
				CFG_OUTPUT_WIDTH: cfg_q.output_width        <= cfg_data[DIM_W-1:0];
				CFG_FRAME_ROWS:   cfg_q.frame_rows          <= cfg_data[DIM_W-1:0];
				CFG_HORIZ_FACTOR: cfg_q.horiz_chroma_factor <= cfg_data[FACT_W-1:0];
				CFG_VERT_FACTOR:  cfg_q.vert_chroma_factor  <= cfg_data[FACT_W-1:0];
				CFG_PAD_LUMA:     cfg_q.pad_luma            <= cfg_data;
				CFG_PAD_CB:       cfg_q.pad_cb              <= cfg_data;
				CFG_PAD_CR:       cfg_q.pad_cr              <= cfg_data;
				default:          cfg_q                     <= cfg_q;
			endcase
		end
	end

	ypcu_front #(
		.MAX_WIDTH   (MAX_WIDTH),
		.MAX_HEIGHT  (MAX_HEIGHT),
		.MAX_PAD     (MAX_PAD),
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.push    (push),
		.full    (full),
		.source  (source),
		.q_count (q_count),
		.q_push  (q_push),
		.q_data  (q_wdata)
	);

	ypcu_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.head   (q_head),
		.valid  (q_valid),
		.count  (q_count)
	);

	ypcu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head       (q_head),
		.head_valid (q_valid),
		.head_pop   (q_pop),
		.empty      (empty),
		.pop        (pop),
		.result     (result)
	);

endmodule

/* dv/tb_yuv_pad_chroma_upsample_444_unit.sv */
module tb_yuv_pad_chroma_upsample_444_unit;
	import ypcu_pkg::*;

	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [PIX_W-1:0]     cfg_data  = '0;
	logic                 push      = 1'b0;
	logic                 full;
	in_item_t             source    = '0;
	logic                 empty;
	logic                 pop       = 1'b0;
	out_item_t            result;

	cfg_t      regs_now = CFG_RESET;
	in_item_t  pending_pixels[$];
	out_item_t expected_pixels[$];
	int        send_idle_pct  = 0;
	int        recv_stall_pct = 0;
	logic      rx_hold        = 1'b0;
	int        mismatches     = 0;
	int        results_seen   = 0;

	// upsampler state as seen after reset
	int               col_cnt = 0;
	int               row_cnt = 0;
	int               h_phase = 0;
	int               v_phase = 0;
	logic [PIX_W-1:0] held_cb = '0;
	logic [PIX_W-1:0] held_cr = '0;
	logic [PIX_W-1:0] cb_line [MAX_WIDTH_DEF];
	logic [PIX_W-1:0] cr_line [MAX_WIDTH_DEF];

	yuv_pad_chroma_upsample_444_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.full      (full),
		.source    (source),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int lim(int v, int hi);
		if (v < 1)
			return 1;
		return (v > hi) ? hi : v;
	endfunction

	function automatic int frame_len();
		return lim(regs_now.active_width, MAX_WIDTH_DEF) *
			lim(regs_now.frame_rows, MAX_HEIGHT_DEF);
	endfunction

	// expands one source pixel into its padded 4:4:4 output run
	function automatic void upsample_pixel(in_item_t px);
		int        aw, ow, fr, hf, vf, pad, groups, ci;
		bit        row_last, frame_last;
		out_item_t pad_px, px_out;
		out_item_t run[$];
		aw = lim(regs_now.active_width, MAX_WIDTH_DEF);
		ow = regs_now.output_width;
		fr = lim(regs_now.frame_rows, MAX_HEIGHT_DEF);
		hf = lim(regs_now.horiz_chroma_factor, 4);
		vf = lim(regs_now.vert_chroma_factor, 4);
		pad = (ow > aw) ? ow - aw : 0;
		if (pad > MAX_PAD_DEF)
			pad = MAX_PAD_DEF;
		row_last = (col_cnt + 1 >= aw);
		frame_last = (row_cnt + 1 >= fr);

		pad_px = '0;
		pad_px.luma_out = regs_now.pad_luma;
		pad_px.cb_out = regs_now.pad_cb;
		pad_px.cr_out = regs_now.pad_cr;
		pad_px.is_padding = 1'b1;
		if (col_cnt == 0)
			repeat (pad / 2) run.push_back(pad_px);

		groups = (aw / hf == 0) ? 1 : aw / hf;
		ci = (col_cnt / hf >= groups) ? groups - 1 : col_cnt / hf;
		px_out = '0;
		px_out.luma_out = px.luma_in;
		if (v_phase == 0) begin
			// sample row: capture only at the head of a full group
			if (h_phase == 0 && col_cnt / hf < groups) begin
				held_cb = px.cb_in;
				held_cr = px.cr_in;
				cb_line[ci] = held_cb;
				cr_line[ci] = held_cr;
			end
			px_out.cb_out = held_cb;
			px_out.cr_out = held_cr;
		end else begin
			px_out.cb_out = cb_line[ci];
			px_out.cr_out = cr_line[ci];
		end
		run.push_back(px_out);
		if (row_last)
			repeat (pad - pad / 2) run.push_back(pad_px);

		px_out = run.pop_back();
		px_out.last_in_run = 1'b1;
		px_out.row_end = row_last;
		px_out.frame_end = row_last && frame_last;
		run.push_back(px_out);
		foreach (run[i])
			expected_pixels.push_back(run[i]);

		if (row_last) begin
			col_cnt = 0;
			h_phase = 0;
			if (frame_last) begin
				row_cnt = 0;
				v_phase = 0;
			end else begin
				row_cnt = (row_cnt + 1) & 'h7FF;
				v_phase = (v_phase + 1 >= vf) ? 0 : v_phase + 1;
			end
		end else begin
			col_cnt = (col_cnt + 1) & 'h7FF;
			h_phase = (h_phase + 1 >= hf) ? 0 : h_phase + 1;
		end
	endfunction

	function automatic void queue_random(int n);
		in_item_t px;
		repeat (n) begin
			px.luma_in = PIX_W'($urandom);
			px.cb_in = PIX_W'($urandom);
			px.cr_in = PIX_W'($urandom);
			pending_pixels.push_back(px);
		end
	endfunction

	task automatic report_mismatch(string what, logic [PIX_W-1:0] got,
			logic [PIX_W-1:0] want);
		mismatches++;
		if (mismatches <= 50)
			$display("%0t: result %0d %s: got %h, expected %h", $time, results_seen, what,
				got, want);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [PIX_W-1:0] val);
		logic [PIX_W-1:0] keep;
		case (idx)
			CFG_ACTIVE_WIDTH, CFG_OUTPUT_WIDTH, CFG_FRAME_ROWS: keep = 16'h0FFF;
			CFG_HORIZ_FACTOR, CFG_VERT_FACTOR: keep = 16'h0007;
			default: keep = 16'hFFFF;
		endcase
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		// bits above the register width are don't-care: put noise on them
		cfg_data <= (val & keep) | (PIX_W'($urandom) & ~keep);
	endtask

	task automatic apply_regs(cfg_t r);
		regs_now = r;
		write_reg(CFG_ACTIVE_WIDTH, PIX_W'(r.active_width));
		write_reg(CFG_OUTPUT_WIDTH, PIX_W'(r.output_width));
		write_reg(CFG_FRAME_ROWS, PIX_W'(r.frame_rows));
		write_reg(CFG_HORIZ_FACTOR, PIX_W'(r.horiz_chroma_factor));
		write_reg(CFG_VERT_FACTOR, PIX_W'(r.vert_chroma_factor));
		write_reg(CFG_PAD_LUMA, r.pad_luma);
		write_reg(CFG_PAD_CB, r.pad_cb);
		write_reg(CFG_PAD_CR, r.pad_cr);
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic wait_idle();
		while (pending_pixels.size() != 0 || push || expected_pixels.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	always @(posedge clk) begin : pixel_driver
		if (arst_n) begin
			if (push && !full)
				upsample_pixel(source);
			if (!push || !full) begin
				if (pending_pixels.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					source <= pending_pixels.pop_front();
					push <= 1'b1;
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : result_monitor
		out_item_t want;
		if (arst_n) begin
			if (pop && !empty) begin
				if (expected_pixels.size() == 0) begin
					report_mismatch("unexpected transaction", result.luma_out, '0);
				end else begin
					want = expected_pixels.pop_front();
					if (result.luma_out !== want.luma_out)
						report_mismatch("luma_out", result.luma_out, want.luma_out);
					if (result.cb_out !== want.cb_out)
						report_mismatch("cb_out", result.cb_out, want.cb_out);
					if (result.cr_out !== want.cr_out)
						report_mismatch("cr_out", result.cr_out, want.cr_out);
					if (result.is_padding !== want.is_padding)
						report_mismatch("is_padding", result.is_padding, want.is_padding);
					if (result.last_in_run !== want.last_in_run)
						report_mismatch("last_in_run", result.last_in_run, want.last_in_run);
					if (result.row_end !== want.row_end)
						report_mismatch("row_end", result.row_end, want.row_end);
					if (result.frame_end !== want.frame_end)
						report_mismatch("frame_end", result.frame_end, want.frame_end);
				end
				results_seen++;
			end
			pop <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	initial begin : stimulus
		cfg_t r;
		int   phase, queued, n;
		int   send_idle [4];
		int   recv_stall [4];
		bit   held;
		send_idle = '{0, 73, 0, 24};
		recv_stall = '{0, 0, 73, 24};
		held = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// pad saturated and split evenly, zero factors and rows, extreme values
		r = CFG_RESET;
		r.active_width = 12'd4;
		r.output_width = 12'hFFF;
		r.frame_rows = 12'd0;
		r.horiz_chroma_factor = 3'd0;
		r.vert_chroma_factor = 3'd0;
		r.pad_luma = 16'hFFFF;
		r.pad_cb = 16'h0000;
		r.pad_cr = 16'hFFFF;
		apply_regs(r);
		pending_pixels.push_back(in_item_t'{luma_in: 16'hFFFF, cb_in: 16'hFFFF, cr_in: 16'hFFFF});
		pending_pixels.push_back(in_item_t'{luma_in: 16'h0000, cb_in: 16'h0000, cr_in: 16'h0000});
		pending_pixels.push_back(in_item_t'{luma_in: 16'hFFFF, cb_in: 16'h0000, cr_in: 16'hFFFF});
		pending_pixels.push_back(in_item_t'{luma_in: 16'h0000, cb_in: 16'hFFFF, cr_in: 16'h0000});
		wait_idle();

		// row narrower than one group, target narrower than source, factors above 4
		r.active_width = 12'd3;
		r.output_width = 12'd2;
		r.frame_rows = 12'd2;
		r.horiz_chroma_factor = 3'd7;
		r.vert_chroma_factor = 3'd5;
		r.pad_luma = 16'h0000;
		r.pad_cb = 16'hFFFF;
		r.pad_cr = 16'h0000;
		apply_regs(r);
		queue_random(frame_len());
		wait_idle();

		// partial group at the row end, then width and rows cut mid-row
		r.active_width = 12'd5;
		r.output_width = 12'd6;
		r.frame_rows = 12'd4;
		r.horiz_chroma_factor = 3'd2;
		r.vert_chroma_factor = 3'd2;
		r.pad_luma = PIX_W'($urandom);
		r.pad_cb = PIX_W'($urandom);
		r.pad_cr = PIX_W'($urandom);
		apply_regs(r);
		queue_random(8);
		wait_idle();
		r.active_width = 12'd0;
		r.frame_rows = 12'd0;
		apply_regs(r);
		queue_random(1);
		wait_idle();

		// start of the widest row with the largest pad; fills the low line store entries
		r.active_width = 12'hFFF;
		r.output_width = 12'd2110;
		r.frame_rows = 12'd1;
		r.horiz_chroma_factor = 3'd1;
		r.vert_chroma_factor = 3'd1;
		apply_regs(r);
		queue_random(32);
		wait_idle();
		// tallest single-column frame, cut short; the narrower width ends the row
		r.active_width = 12'd1;
		r.output_width = 12'd1;
		r.frame_rows = 12'hFFF;
		r.horiz_chroma_factor = 3'd4;
		r.vert_chroma_factor = 3'd4;
		apply_regs(r);
		queue_random(32);
		wait_idle();
		// one-row frame closes the frame so random frames start at row 0
		r.frame_rows = 12'd1;
		apply_regs(r);
		queue_random(1);
		wait_idle();

		for (phase = 0; phase < 4; phase++) begin
			send_idle_pct = send_idle[phase];
			recv_stall_pct = recv_stall[phase];
			queued = 0;
			while (queued < 50) begin
				r.active_width = ($urandom_range(15) == 0) ? 12'd0 : 12'($urandom_range(1, 24));
				r.frame_rows = ($urandom_range(15) == 0) ? 12'd0 : 12'($urandom_range(1, 5));
				case ($urandom_range(3))
					0: r.output_width = 12'($urandom_range(0, lim(r.active_width, 2048)));
					1: r.output_width = 12'(lim(r.active_width, 2048) + $urandom_range(0, 70));
					2: r.output_width = 12'hFFF;
					default: r.output_width = 12'($urandom);
				endcase
				r.horiz_chroma_factor = ($urandom_range(3) == 0) ? 3'($urandom) :
					3'($urandom_range(1, 4));
				r.vert_chroma_factor = ($urandom_range(3) == 0) ? 3'($urandom) :
					3'($urandom_range(1, 4));
				r.pad_luma = PIX_W'($urandom);
				r.pad_cb = PIX_W'($urandom);
				r.pad_cr = PIX_W'($urandom);
				apply_regs(r);
				n = frame_len() * $urandom_range(1, 2);
				queue_random(n);
				queued += n;
				if (phase == 2 && !held) begin
					held = 1'b1;
					// result side closed for a long stretch while the sender keeps offering
					while (pending_pixels.size() < 40) begin
						queue_random(frame_len());
						queued += frame_len();
					end
					@(posedge clk);
					rx_hold <= 1'b1;
					repeat (400) @(posedge clk);
					rx_hold <= 1'b0;
				end
				wait_idle();
			end
		end

		if (mismatches == 0)
			$display("yuv_pad_chroma_upsample_444_unit: match");
		else
			$display("yuv_pad_chroma_upsample_444_unit: mismatch");
		$finish;
	end

	initial begin : watchdog
		#5_000_000;
		$display("yuv_pad_chroma_upsample_444_unit: mismatch");
		$finish;
	end

endmodule
